// ===== sv/multilevel_feedback_task_scheduler_top_assert.svh =====
// assertion macros shared by the scheduler checker
`ifndef MULTILEVEL_FEEDBACK_TASK_SCHEDULER_TOP_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_TASK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define MLFTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define MLFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlfts_pkg.sv =====
// types and constants of the feedback task scheduler
package mlfts_pkg;

    // request commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TASK_COUNT = 2'd0;
    localparam logic [1:0] REG_QUANTUM    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam int          SLICE_W      = 20;
    localparam logic [19:0] SLICE_MAX    = 20'hFFFFF;
    localparam logic [19:0] LONG_SLICE   = 20'd1000000;
    localparam logic [1:0]  LOWEST_LEVEL = 2'd2;
    localparam logic [31:0] TIME_MAX     = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // best candidate handed along the cell row
    typedef struct packed {
        logic        found;
        logic [1:0]  level;
        logic [31:0] arrival;
        logic        none_left;
    } cand_t;

    // per-cell update strobes
    typedef struct packed {
        logic load;
        logic demote;
        logic finish;
    } cell_cmd_t;

endpackage

// ===== sv/multilevel_feedback_task_scheduler_top.sv =====
// top level of the three-level feedback task scheduler
// Each request (load, tick or finish) updates the task row and the running
// task in its accept cycle; the best dispatch candidate then ripples through
// a row of MAX_TASKS cells, one cell per cycle, and the decide state turns
// it into the result, waiting there while the output register is stalled;
// only then is the next request accepted. The input is taken again while a
// result still waits in the output register.
module multilevel_feedback_task_scheduler_top
    import mlfts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  task_index,
    input  logic [31:0] arrival_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        run_valid,
    output logic [3:0]  run_task,
    output logic [1:0]  run_level,
    output logic        dispatched,
    output logic        preempted,
    output logic        all_done,
    output logic        timed_out,
    output logic        ignored
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [CNT_W-1:0]   scan_cnt_next;
    logic [4:0]         task_count_reg;
    logic [15:0]        quantum_reg;
    logic [31:0]        timeout_reg;
    logic [31:0]        cur_time_reg;
    logic [31:0]        cur_time_next;
    logic               run_active_reg;
    logic               run_active_next;
    logic [IDX_W-1:0]   run_index_reg;
    logic [IDX_W-1:0]   run_index_next;
    logic [1:0]         cur_level_reg;
    logic [1:0]         cur_level_next;
    logic [SLICE_W-1:0] slice_reg;
    logic [SLICE_W-1:0] slice_next;
    logic               preempt_reg;
    logic               preempt_next;
    logic               ignored_reg;
    logic               ignored_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic               res_run_valid_reg;
    logic               res_run_valid_next;
    logic [3:0]         res_run_task_reg;
    logic [3:0]         res_run_task_next;
    logic [1:0]         res_run_level_reg;
    logic [1:0]         res_run_level_next;
    logic               res_dispatched_reg;
    logic               res_dispatched_next;
    logic               res_preempted_reg;
    logic               res_preempted_next;
    logic               res_all_done_reg;
    logic               res_all_done_next;
    logic               res_timed_out_reg;
    logic               res_timed_out_next;
    logic               res_ignored_reg;
    logic               res_ignored_next;

    logic               accept;
    logic               out_free;
    logic               scan_last;
    logic               load_en;
    logic               demote_en;
    logic               finish_en;
    logic [15:0]        quantum_eff;
    logic [SLICE_W-1:0] slice_inc;
    logic [SLICE_W-1:0] slice_limit;
    logic               do_dispatch;
    logic [IDX_W+3:0]   task_wide;

    cell_cmd_t          cell_cmd   [MAX_TASKS];
    cand_t              cand_chain [MAX_TASKS+1];
    logic [IDX_W-1:0]   idx_chain  [MAX_TASKS+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 5'd1;
            quantum_reg    <= 16'd1;
            timeout_reg    <= TIME_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TASK_COUNT: task_count_reg <= cfg_data[4:0];
                REG_QUANTUM:    quantum_reg    <= cfg_data[15:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        accept    = 1'b0;
        scan_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            ST_SCAN:
            begin
                scan_last = (scan_cnt_reg == CNT_W'(MAX_TASKS - 1));
            end
            ST_DECIDE:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_free = !res_valid_reg || !out_stall;

    // slice bookkeeping
    always_comb
    begin
        quantum_eff = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
        slice_inc   = (slice_reg == SLICE_MAX) ? slice_reg : slice_reg + SLICE_W'(1);
        case (cur_level_reg)
            2'd0:    slice_limit = {4'd0, quantum_eff};
            2'd1:    slice_limit = {3'd0, quantum_eff, 1'b0};
            default: slice_limit = LONG_SLICE;
        endcase
    end

    // request update of the running task and time, and dispatch in the decide state
    always_comb
    begin
        cur_time_next   = cur_time_reg;
        run_active_next = run_active_reg;
        run_index_next  = run_index_reg;
        cur_level_next  = cur_level_reg;
        slice_next      = slice_reg;
        preempt_next    = preempt_reg;
        ignored_next    = ignored_reg;
        load_en         = 1'b0;
        demote_en       = 1'b0;
        finish_en       = 1'b0;
        do_dispatch     = 1'b0;
        if (accept)
        begin
            preempt_next = 1'b0;
            ignored_next = 1'b0;
            case (cmd)
                CMD_LOAD:
                begin
                    load_en = 1'b1;
                    if (int'(task_index) == int'(run_index_reg))
                    begin
                        cur_level_next = 2'd0;
                    end
                end
                CMD_TICK:
                begin
                    if (cur_time_reg != TIME_MAX)
                    begin
                        cur_time_next = cur_time_reg + 32'd1;
                    end
                    if (run_active_reg)
                    begin
                        slice_next = slice_inc;
                        if (slice_inc >= slice_limit)
                        begin
                            demote_en       = 1'b1;
                            run_active_next = 1'b0;
                            slice_next      = '0;
                            preempt_next    = 1'b1;
                            if (cur_level_reg < LOWEST_LEVEL)
                            begin
                                cur_level_next = cur_level_reg + 2'd1;
                            end
                        end
                    end
                end
                CMD_FINISH:
                begin
                    if (run_active_reg)
                    begin
                        finish_en       = 1'b1;
                        run_active_next = 1'b0;
                        slice_next      = '0;
                    end
                    else
                    begin
                        ignored_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_DECIDE && out_free)
        begin
            do_dispatch = !run_active_reg && (cur_time_reg < timeout_reg) &&
                          cand_chain[MAX_TASKS].found;
            if (do_dispatch)
            begin
                run_active_next = 1'b1;
                run_index_next  = idx_chain[MAX_TASKS];
                cur_level_next  = cand_chain[MAX_TASKS].level;
                slice_next      = '0;
            end
        end
    end

    // result assembly
    always_comb
    begin
        task_wide           = {4'd0, run_index_next};
        res_valid_next      = res_valid_reg && out_stall;
        res_run_valid_next  = res_run_valid_reg;
        res_run_task_next   = res_run_task_reg;
        res_run_level_next  = res_run_level_reg;
        res_dispatched_next = res_dispatched_reg;
        res_preempted_next  = res_preempted_reg;
        res_all_done_next   = res_all_done_reg;
        res_timed_out_next  = res_timed_out_reg;
        res_ignored_next    = res_ignored_reg;
        if (state_reg == ST_DECIDE && out_free)
        begin
            res_valid_next      = 1'b1;
            res_run_valid_next  = run_active_next;
            res_run_task_next   = run_active_next ? task_wide[3:0] : 4'd0;
            res_run_level_next  = run_active_next ? cur_level_next : 2'd0;
            res_dispatched_next = do_dispatch;
            res_preempted_next  = preempt_reg;
            res_all_done_next   = cand_chain[MAX_TASKS].none_left;
            res_timed_out_next  = (cur_time_reg >= timeout_reg);
            res_ignored_next    = ignored_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            cur_time_reg   <= 32'd0;
            run_active_reg <= 1'b0;
            run_index_reg  <= '0;
            cur_level_reg  <= 2'd0;
            slice_reg      <= '0;
            preempt_reg    <= 1'b0;
            ignored_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cur_time_reg   <= cur_time_next;
            run_active_reg <= run_active_next;
            run_index_reg  <= run_index_next;
            cur_level_reg  <= cur_level_next;
            slice_reg      <= slice_next;
            preempt_reg    <= preempt_next;
            ignored_reg    <= ignored_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_run_valid_reg  <= res_run_valid_next;
        res_run_task_reg   <= res_run_task_next;
        res_run_level_reg  <= res_run_level_next;
        res_dispatched_reg <= res_dispatched_next;
        res_preempted_reg  <= res_preempted_next;
        res_all_done_reg   <= res_all_done_next;
        res_timed_out_reg  <= res_timed_out_next;
        res_ignored_reg    <= res_ignored_next;
    end

    // head of the candidate row
    assign cand_chain[0] = '{found: 1'b0, level: 2'd0, arrival: 32'd0, none_left: 1'b1};
    assign idx_chain[0]  = '0;

    // row of task cells
    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        assign cell_cmd[k].load   = load_en && (int'(task_index) == k);
        assign cell_cmd[k].demote = demote_en && (int'(run_index_reg) == k);
        assign cell_cmd[k].finish = finish_en && (int'(run_index_reg) == k);

        mlfts_cell #(
            .CELL_IDX (k),
            .IDX_W    (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cell_cmd[k]),
            .load_arrival (arrival_time),
            .cur_time     (cur_time_reg),
            .task_count   (task_count_reg),
            .cand_in      (cand_chain[k]),
            .idx_in       (idx_chain[k]),
            .cand_out     (cand_chain[k+1]),
            .idx_out      (idx_chain[k+1])
        );
    end

    assign out_valid  = res_valid_reg;
    assign run_valid  = res_run_valid_reg;
    assign run_task   = res_run_task_reg;
    assign run_level  = res_run_level_reg;
    assign dispatched = res_dispatched_reg;
    assign preempted  = res_preempted_reg;
    assign all_done   = res_all_done_reg;
    assign timed_out  = res_timed_out_reg;
    assign ignored    = res_ignored_reg;

endmodule

// ===== sv/mlfts_cell.sv =====
// one task table entry with its stage of the candidate scan
module mlfts_cell
    import mlfts_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [31:0]      load_arrival,
    input  logic [31:0]      cur_time,
    input  logic [4:0]       task_count,
    input  cand_t            cand_in,
    input  logic [IDX_W-1:0] idx_in,
    output cand_t            cand_out,
    output logic [IDX_W-1:0] idx_out
);

    logic [31:0]      arrival_reg;
    logic [31:0]      arrival_next;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;
    logic             done_reg;
    logic             done_next;
    cand_t            cand_reg;
    cand_t            cand_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             counted;
    logic             eligible;
    logic             better;

    // entry update from the current request
    always_comb
    begin
        arrival_next = arrival_reg;
        level_next   = level_reg;
        done_next    = done_reg;
        if (cmd.load)
        begin
            arrival_next = load_arrival;
            level_next   = 2'd0;
            done_next    = 1'b0;
        end
        else if (cmd.demote)
        begin
            if (level_reg < LOWEST_LEVEL)
            begin
                level_next = level_reg + 2'd1;
            end
        end
        else if (cmd.finish)
        begin
            done_next = 1'b1;
        end
    end

    // compare own entry against the candidate from the left
    always_comb
    begin
        counted  = int'(task_count) > CELL_IDX;
        eligible = counted && !done_reg && (arrival_reg <= cur_time);
        better   = !cand_in.found || (level_reg < cand_in.level) ||
                   ((level_reg == cand_in.level) && (arrival_reg < cand_in.arrival));
        cand_next           = cand_in;
        idx_next            = idx_in;
        cand_next.none_left = cand_in.none_left && !(counted && !done_reg);
        if (eligible && better)
        begin
            cand_next.found   = 1'b1;
            cand_next.level   = level_reg;
            cand_next.arrival = arrival_reg;
            idx_next          = IDX_W'(CELL_IDX);
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        arrival_reg <= arrival_next;
    end

    // entry flags and scan stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 2'd0;
            done_reg  <= 1'b0;
            cand_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            level_reg <= level_next;
            done_reg  <= done_next;
            cand_reg  <= cand_next;
            idx_reg   <= idx_next;
        end
    end

    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;

endmodule

// ===== sv/mlfts_checker.sv =====
// port-level checks of the scheduler and their binding to the top level
`include "multilevel_feedback_task_scheduler_top_assert.svh"

module mlfts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        run_valid,
    input logic [3:0]  run_task,
    input logic [1:0]  run_level,
    input logic        dispatched,
    input logic        preempted,
    input logic        ignored
);

    // a stalled result holds its running task
    `MLFTS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(run_task) && $stable(run_level), "stalled result changed")

    // an idle result reports no task and level
    `MLFTS_ASSERT_IMPLY(a_idle_zero, clk, rst_n, out_valid && !run_valid, run_task == 4'd0 && run_level == 2'd0, "idle result not zero")

    // a new dispatch always leaves a task running
    `MLFTS_ASSERT_IMPLY(a_disp_run, clk, rst_n, out_valid && dispatched, run_valid, "dispatch without running task")

    // expiry and a stray finish come from different requests
    `MLFTS_ASSERT_IMPLY(a_excl, clk, rst_n, out_valid && preempted, !ignored, "preempted and ignored together")

    // levels stop at the lowest one
    `MLFTS_ASSERT_IMPLY(a_level, clk, rst_n, out_valid, run_level != 2'd3, "level out of range")

endmodule

bind multilevel_feedback_task_scheduler_top mlfts_checker u_mlfts_checker (.*);

// ===== dv/tb.sv =====
// self-checking testbench for the three-level feedback task scheduler
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfts_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam logic [1:0]  CMD_NONE    = 2'd3;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASE_ITEMS = 185;
    localparam int          TAIL_CYCLES = 40;

    // one scheduler answer, same field order as the result ports
    typedef struct packed {
        logic       run_valid;
        logic [3:0] run_task;
        logic [1:0] run_level;
        logic       dispatched;
        logic       preempted;
        logic       all_done;
        logic       timed_out;
        logic       ignored;
    } sched_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // directed row: a request, or a register write when kind is ROW_CFG
    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    op;
        logic [1:0]    reg_idx;
        logic [3:0]    idx;
        logic [31:0]   value;
        logic          typed;
        sched_result_t want;
    } plan_row_t;

    // want = {run_valid, run_task, run_level, dispatched/preempted/all_done/timed_out/ignored}
    localparam int PLAN_LEN = 28;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // first load after reset runs at once
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b1, 4'd0, 2'd0, 5'b10000}},
        // unknown command leaves the running task alone
        '{ROW_REQ, CMD_NONE,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b0, 4'd0, 2'd0, 5'b00100}},
        // finish with nothing running
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b0, 4'd0, 2'd0, 5'b00101}},
        // reload of a finished entry, then demotion down to the lowest level
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_TICK,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_TICK,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_TICK,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        // load of the running task resets its level only
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_TICK,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        // timeout at zero: running task goes on, no new dispatch
        '{ROW_CFG, CMD_LOAD,   REG_TIMEOUT,    4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_NONE,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b1, 4'd0, 2'd1, 5'b00010}},
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b0, 4'd0, 2'd0, 5'b00110}},
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b1,
          {1'b0, 4'd0, 2'd0, 5'b00010}},
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd1, 32'd4, 1'b0, '0},
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd2, 32'd2, 1'b0, '0},
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd3, 32'hFFFF_FFFF, 1'b0, '0},
        // four entries, zero quantum
        '{ROW_CFG, CMD_LOAD,   REG_TIMEOUT,    4'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_CFG, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd4, 1'b0, '0},
        '{ROW_CFG, CMD_LOAD,   REG_QUANTUM,    4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_NONE,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_TICK,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_LOAD,   REG_TASK_COUNT, 4'd3, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        // shrink the count below the running task
        '{ROW_CFG, CMD_LOAD,   REG_TASK_COUNT, 4'd0, 32'd2, 1'b0, '0},
        '{ROW_REQ, CMD_NONE,   REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0},
        '{ROW_REQ, CMD_FINISH, REG_TASK_COUNT, 4'd0, 32'd0, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TASK_COUNT;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_LOAD;
    logic [3:0]  task_index = '0;
    logic [31:0] arrival_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        run_valid;
    logic [3:0]  run_task;
    logic [1:0]  run_level;
    logic        dispatched;
    logic        preempted;
    logic        all_done;
    logic        timed_out;
    logic        ignored;

    // typed answer travelling with the request, if the row has one
    logic          row_typed = 1'b0;
    sched_result_t row_want = '0;

    // scheduler copy kept by the testbench
    logic [4:0]  cfg_count = 5'd1;
    logic [15:0] cfg_quantum = 16'd1;
    logic [31:0] cfg_timeout = TIME_MAX;
    logic [31:0] sched_time = '0;
    logic        sched_busy = 1'b0;
    logic [3:0]  sched_run = '0;
    logic [19:0] slice_cnt = '0;
    logic [31:0] arr_tab [TABLE_DEPTH];
    logic [1:0]  lvl_tab [TABLE_DEPTH] = '{default: '0};
    logic        done_tab [TABLE_DEPTH] = '{default: 1'b0};

    sched_result_t answer_q [$];

    int          fail_count = 0;
    int          useful_count = 0;
    int          result_count = 0;
    int          dispatch_total = 0;
    int          preempt_total = 0;
    int          timeout_total = 0;
    int          stall_left = 0;
    logic [31:0] cycle_count = '0;
    logic        calm;

    multilevel_feedback_task_scheduler_top DUT (.*);

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // quiet stretches with no idling on either side
    assign calm = cycle_count[11] & cycle_count[10];

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [19:0] slice_limit(input logic [1:0] lvl);
        logic [19:0] q;
        q = (cfg_quantum == 16'd0) ? 20'd1 : {4'd0, cfg_quantum};
        if (lvl == 2'd0)
            return q;
        if (lvl == 2'd1)
            return q << 1;
        return LONG_SLICE;
    endfunction

    // apply one request to the scheduler copy and return its answer
    function automatic sched_result_t sched_predict(input logic [1:0] op,
                                                     input logic [3:0] idx,
                                                     input logic [31:0] arr);
        sched_result_t res;
        logic          found;
        logic [3:0]    best;
        logic [1:0]    best_lvl;
        logic [31:0]   best_arr;
        int            n;
        res = '0;
        n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
        case (op)
            CMD_LOAD:
            begin
                arr_tab[idx] = arr;
                lvl_tab[idx] = 2'd0;
                done_tab[idx] = 1'b0;
            end
            CMD_TICK:
            begin
                if (sched_time != TIME_MAX)
                    sched_time = sched_time + 32'd1;
                if (sched_busy)
                begin
                    if (slice_cnt != SLICE_MAX)
                        slice_cnt = slice_cnt + 20'd1;
                    // slice expired: demote and release
                    if (slice_cnt >= slice_limit(lvl_tab[sched_run]))
                    begin
                        if (lvl_tab[sched_run] < LOWEST_LEVEL)
                            lvl_tab[sched_run] = lvl_tab[sched_run] + 2'd1;
                        sched_busy = 1'b0;
                        slice_cnt = '0;
                        res.preempted = 1'b1;
                    end
                end
            end
            CMD_FINISH:
            begin
                if (sched_busy)
                begin
                    done_tab[sched_run] = 1'b1;
                    sched_busy = 1'b0;
                    slice_cnt = '0;
                end
                else
                    res.ignored = 1'b1;
            end
            default:
            begin
            end
        endcase

        // pick lowest level, then earliest arrival, then lowest index
        if (!sched_busy && sched_time < cfg_timeout)
        begin
            found = 1'b0;
            best = '0;
            best_lvl = '0;
            best_arr = '0;
            for (int i = 0; i < n; i++)
            begin
                if (done_tab[i] || arr_tab[i] > sched_time)
                    continue;
                if (!found || lvl_tab[i] < best_lvl ||
                    (lvl_tab[i] == best_lvl && arr_tab[i] < best_arr))
                begin
                    found = 1'b1;
                    best = i[3:0];
                    best_lvl = lvl_tab[i];
                    best_arr = arr_tab[i];
                end
            end
            if (found)
            begin
                sched_busy = 1'b1;
                sched_run = best;
                slice_cnt = '0;
                res.dispatched = 1'b1;
            end
        end

        res.all_done = 1'b1;
        for (int i = 0; i < n; i++)
            if (!done_tab[i])
                res.all_done = 1'b0;

        res.run_valid = sched_busy;
        res.run_task = sched_busy ? sched_run : 4'd0;
        res.run_level = sched_busy ? lvl_tab[sched_run] : 2'd0;
        res.timed_out = (sched_time >= cfg_timeout);
        return res;
    endfunction

    function automatic void field_check(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // request and result monitor
    always @(posedge clk)
    begin : monitor
        sched_result_t predicted;
        sched_result_t got;
        sched_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = sched_predict(cmd, task_index, arrival_time);
                answer_q.push_back(row_typed ? row_want : predicted);
                if (cmd != CMD_NONE && !predicted.ignored)
                    useful_count++;
                dispatch_total += predicted.dispatched;
                preempt_total += predicted.preempted;
                timeout_total += predicted.timed_out;
            end
            if (out_valid && !out_stall)
            begin
                got = '{run_valid, run_task, run_level, dispatched, preempted,
                        all_done, timed_out, ignored};
                result_count++;
                if (answer_q.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    field_check("run_valid", want.run_valid, got.run_valid);
                    field_check("run_task", want.run_task, got.run_task);
                    field_check("run_level", want.run_level, got.run_level);
                    field_check("dispatched", want.dispatched, got.dispatched);
                    field_check("preempted", want.preempted, got.preempted);
                    field_check("all_done", want.all_done, got.all_done);
                    field_check("timed_out", want.timed_out, got.timed_out);
                    field_check("ignored", want.ignored, got.ignored);
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= gap_len() - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // drive one request and hold it until taken; valid stays high afterwards
    task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                                input logic [31:0] arr, input logic typed,
                                input sched_result_t want);
        int gap;
        cfg_we <= 1'b0;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            gap = gap_len();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        task_index <= idx;
        arrival_time <= arr;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait until every answer is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    // one register write; cfg_we is lowered by the next request
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_TASK_COUNT: cfg_count = data[4:0];
            REG_QUANTUM:    cfg_quantum = data[15:0];
            REG_TIMEOUT:    cfg_timeout = data;
            default:
            begin
            end
        endcase
    endtask

    // random request, mostly arrivals close to the current time
    task automatic pick_request(output logic [1:0] op, output logic [3:0] idx,
                                output logic [31:0] arr);
        int r;
        int n;
        n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
        r = $urandom_range(0, 99);
        idx = 4'($urandom_range(0, TABLE_DEPTH - 1));
        arr = $urandom;
        if (r < 45)
            op = CMD_TICK;
        else if (r < 70)
            op = CMD_FINISH;
        else if (r < 94)
        begin
            op = CMD_LOAD;
            if ($urandom_range(0, 3) != 0 && n > 0)
                idx = 4'($urandom_range(0, n - 1));
            r = $urandom_range(0, 9);
            if (r < 7)
                arr = sched_time + $urandom_range(0, 25);
            else if (r == 7)
                arr = (sched_time > 20) ? sched_time - $urandom_range(0, 20) : 32'd0;
            else if (r == 9)
                arr = $urandom_range(0, 1) ? TIME_MAX : 32'd0;
        end
        else
            op = CMD_NONE;
    endtask

    // stimulus
    initial
    begin
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] arr;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (PLAN[k].kind == ROW_CFG)
            begin
                if (k == 0 || PLAN[k - 1].kind != ROW_CFG)
                    drain();
                write_reg(PLAN[k].reg_idx, PLAN[k].value);
            end
            else
                send_request(PLAN[k].op, PLAN[k].idx, PLAN[k].value,
                             PLAN[k].typed, PLAN[k].want);
        end

        // fill every entry before wider counts are used
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(CMD_LOAD, i[3:0], sched_time + $urandom_range(0, 12), 1'b0, '0);

        // random phases under different settings
        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(REG_TASK_COUNT, 32'd16);
                    write_reg(REG_QUANTUM, 32'd1);
                    write_reg(REG_TIMEOUT, TIME_MAX);
                end
                1:
                begin
                    write_reg(REG_TASK_COUNT, 32'd5);
                    write_reg(REG_QUANTUM, 32'd3);
                end
                2:
                begin
                    write_reg(REG_TASK_COUNT, 32'd31);
                    write_reg(REG_QUANTUM, 32'd2);
                end
                3:
                begin
                    write_reg(REG_TASK_COUNT, $urandom_range(1, 31));
                    write_reg(REG_QUANTUM, $urandom_range(1, 8));
                end
                4:
                begin
                    write_reg(REG_TASK_COUNT, 32'd16);
                    write_reg(REG_QUANTUM, 32'd65535);
                end
                5:
                begin
                    write_reg(REG_TASK_COUNT, 32'd12);
                    write_reg(REG_QUANTUM, 32'd1);
                    write_reg(REG_TIMEOUT, sched_time + 60);
                end
                6:
                begin
                    write_reg(REG_TASK_COUNT, 32'd16);
                    write_reg(REG_QUANTUM, $urandom_range(0, 65535));
                    write_reg(REG_TIMEOUT, TIME_MAX);
                end
                default:
                begin
                    write_reg(REG_QUANTUM, 32'd2);
                    write_reg(REG_TIMEOUT, $urandom);
                end
            endcase
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                pick_request(op, idx, arr);
                send_request(op, idx, arr, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d effective requests, %0d results checked, %0d mismatches",
                 useful_count, result_count, fail_count);
        $display("summary: %0d dispatches, %0d preemptions, %0d results past timeout",
                 dispatch_total, preempt_total, timeout_total);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
